// ----- hdl/dqec_pkg.sv -----
// Shared types and constants for the dual quadrature encoder counter.
// Used by dqec_channel and dual_quadrature_encoder_counter; no dependencies.
package dqec_pkg;

    typedef enum logic
    {
        CMD_SAMPLE   = 1'b0,
        CMD_SUBTRACT = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t               cmd;
        logic [3:0]         pins;
        logic signed [31:0] offset_a;
        logic signed [31:0] offset_b;
    } sample_t;

    typedef struct packed
    {
        logic signed [31:0] count_a;
        logic signed [31:0] count_b;
    } result_t;

    typedef struct packed
    {
        logic step;
        logic subtract;
    } chan_ctrl_t;

    localparam logic [31:0] STEP_TABLE_RESET = 32'h3443_C11C;
    localparam logic [3:0]  CHAN_A_MASK      = 4'b0101;
    localparam logic [3:0]  CHAN_B_MASK      = 4'b1010;

endpackage

// ----- hdl/dqec_channel.sv -----
// One encoder channel: 4-bit pin history and wrapping position counter.
// Depends on dqec_pkg for the channel control struct.
module dqec_channel
    import dqec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   enable,
    input  chan_ctrl_t             ctrl,
    input  logic [1:0]             pair,
    input  logic signed [31:0]     offset,
    input  logic [31:0]            step_table,
    output logic [COUNT_WIDTH-1:0] pos_next
);

    logic [3:0]             hist_reg;
    logic [3:0]             hist_next;
    logic [COUNT_WIDTH-1:0] pos_reg;
    logic [1:0]             entry;
    logic [COUNT_WIDTH-1:0] delta;
    logic signed [63:0]     offset_wide;
    logic [COUNT_WIDTH-1:0] offset_ext;

    always_comb
    begin
        hist_next   = ctrl.step ? {hist_reg[1:0], pair} : hist_reg;
        entry       = step_table[{hist_next, 1'b0} +: 2];
        delta       = COUNT_WIDTH'(signed'(entry));
        offset_wide = 64'(offset);
        offset_ext  = offset_wide[COUNT_WIDTH-1:0];
        priority if (ctrl.subtract)
            pos_next = pos_reg - offset_ext;
        else if (ctrl.step)
            pos_next = pos_reg + delta;
        else
            pos_next = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            pos_reg  <= '0;
        end
        else if (enable)
        begin
            hist_reg <= hist_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ----- hdl/dual_quadrature_encoder_counter.sv -----
// Dual quadrature encoder counter, top level.
// Depends on dqec_pkg and dqec_channel.
//
// Accepts one item per clock while the input is not stalled: a pin sample or a
// subtract command, and returns both channel positions for every item. An item
// is registered on entry, then one table lookup and one add per channel feed the
// result register, which offers the result once the staged item moves on.
// Throughput is one item per cycle while the result is not stalled. The input
// stalls only while both registers hold an item and the result is stalled. The
// step table register resets to the standard quadrature table and may be
// rewritten through the configuration port while no item is in flight.
module dual_quadrature_encoder_counter
    import dqec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0]            table_reg;
    logic [3:0]             last_pins_reg;
    logic [3:0]             last_pins_next;
    logic                   stage_valid_reg;
    logic                   stage_valid_next;
    sample_t                stage_reg;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    result_t                result_reg;
    result_t                result_next;
    logic                   advance;
    logic                   fire;
    logic                   take;
    logic [3:0]             changed;
    chan_ctrl_t             ctrl_a;
    chan_ctrl_t             ctrl_b;
    logic [COUNT_WIDTH-1:0] pos_a;
    logic [COUNT_WIDTH-1:0] pos_b;
    logic signed [63:0]     wide_a;
    logic signed [63:0]     wide_b;

    assign cfg_ready    = 1'b1;
    assign advance      = !result_valid_reg || !result_stall;
    assign fire         = stage_valid_reg && advance;
    assign sample_stall = stage_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        changed         = stage_reg.pins ^ last_pins_reg;
        ctrl_a.subtract = (stage_reg.cmd == CMD_SUBTRACT);
        ctrl_b.subtract = (stage_reg.cmd == CMD_SUBTRACT);
        ctrl_a.step     = (stage_reg.cmd == CMD_SAMPLE) && |(changed & CHAN_A_MASK);
        ctrl_b.step     = (stage_reg.cmd == CMD_SAMPLE) && |(changed & CHAN_B_MASK);

        last_pins_next = last_pins_reg;
        if (fire && stage_reg.cmd == CMD_SAMPLE)
            last_pins_next = stage_reg.pins;

        stage_valid_next = stage_valid_reg;
        if (!sample_stall)
            stage_valid_next = sample_valid;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = stage_valid_reg;

        wide_a              = 64'(signed'(pos_a));
        wide_b              = 64'(signed'(pos_b));
        result_next.count_a = wide_a[31:0];
        result_next.count_b = wide_b[31:0];
    end

    dqec_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_chan_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (fire),
        .ctrl       (ctrl_a),
        .pair       ({stage_reg.pins[0], stage_reg.pins[2]}),
        .offset     (stage_reg.offset_a),
        .step_table (table_reg),
        .pos_next   (pos_a)
    );

    dqec_channel #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_chan_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (fire),
        .ctrl       (ctrl_b),
        .pair       ({stage_reg.pins[1], stage_reg.pins[3]}),
        .offset     (stage_reg.offset_b),
        .step_table (table_reg),
        .pos_next   (pos_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg        <= STEP_TABLE_RESET;
            last_pins_reg    <= '0;
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                table_reg <= cfg_data;
            last_pins_reg    <= last_pins_next;
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            stage_reg <= sample;
        if (fire)
            result_reg <= result_next;
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> stage_valid_reg && result_valid_reg && result_stall)
        else $error("input stalled while the pipeline had room");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid_reg)
        else $error("processed item produced no result");

    a_subtract_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && stage_reg.cmd == CMD_SUBTRACT) |=> $stable(last_pins_reg))
        else $error("subtract item changed the pin history");

    a_idle_keeps_pins: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(last_pins_reg))
        else $error("pin history changed without an item");

endmodule
